// File: sv/circular_list_cursor_editor_assert.svh
// Assertion macros shared by the checker of the cursor editor.
// Depends on nothing; the including file supplies clock, reset and signals.
`ifndef CIRCULAR_LIST_CURSOR_EDITOR_ASSERT_SVH
`define CIRCULAR_LIST_CURSOR_EDITOR_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define CLCE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define CLCE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/clce_pkg.sv
// Shared types and constants of the circular list cursor editor.
// Used by the top, the free stack and the checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package clce_pkg;

  // Default pool depth and stored word width
  localparam int CLCE_NODES     = 256;
  localparam int CLCE_WORD_BITS = 64;

  // Fixed widths of the command and result words
  localparam int WORD_W   = 64;
  localparam int ACTION_W = 3;
  localparam int COUNT_W  = 9;
  localparam int STATUS_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_EDIT   = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_BACK   = 3'd3,
    ACT_FWD    = 3'd4,
    ACT_READ   = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LINK,
    S_FETCH
  } state_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [WORD_W-1:0]   word;
  } cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0]   current_word;
    logic                is_empty;
    logic [COUNT_W-1:0]  node_count;
    logic                at_head;
    logic [STATUS_W-1:0] status;
  } rsp_t;

  // Free stack controls: read the top entry, commit a pop, push an index
  typedef struct packed {
    logic rd;
    logic pop;
    logic push;
  } fs_ctrl_t;

endpackage

`default_nettype wire

// File: sv/circular_list_cursor_editor.sv
// Top level of the circular list cursor editor: sequencer, node RAMs, free stack.
// Depends on clce_pkg, clce_ram and clce_free_stack.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Commands enter on cmd, taken at a rising edge where start is high and
//   busy is low. Each command yields exactly one response word on rsp,
//   shown for one cycle with done high; the receiver cannot stall it.
//   Path per command, from accept to the next possible accept: read, edit,
//     full insert, insert into an empty list, removal of the only node, and
//     any command on an empty list go from S_IDLE through S_EXEC only; insert
//     into a non-empty list adds S_LINK, and removal, move back and forward add S_FETCH.
//   The link RAMs are read at accept; the added state serves either the second
//   pair of link writes (insert) or the read of the word at the new cursor
//   (remove, move).
//   done rises in the cycle after the last command cycle, while busy is
//   already low, so the next command can be taken in that same cycle.
//   Reset empties the list: the free stack is full, cursor and head are 0.
//   No clearing pass runs; the free stack tracks a low mark instead, and
//   node words and links are valid only once written.
module circular_list_cursor_editor
  import clce_pkg::*;
#(
  parameter int NODES     = CLCE_NODES,
  parameter int WORD_BITS = CLCE_WORD_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t cmd,
  output logic done,
  output rsp_t rsp
);

  localparam int IDX_W = $clog2(NODES);
  localparam int CNT_W = $clog2(NODES + 1);

  state_t state, state_next;

  logic [IDX_W-1:0]     cursor, cursor_next;
  logic [IDX_W-1:0]     head, head_next;
  logic [ACTION_W-1:0]  act_r;
  logic [WORD_BITS-1:0] word_r;
  logic [IDX_W-1:0]     link_nx_r;
  logic [IDX_W-1:0]     link_pv_r;
  logic [IDX_W-1:0]     new_r;

  // RAM ports
  logic                 w_we, w_re;
  logic [IDX_W-1:0]     w_waddr, w_raddr;
  logic [WORD_BITS-1:0] w_wdata, w_rdata;
  logic                 p_we, p_re;
  logic [IDX_W-1:0]     p_waddr, p_wdata, p_rdata;
  logic                 n_we, n_re;
  logic [IDX_W-1:0]     n_waddr, n_wdata, n_rdata;

  // Free stack
  fs_ctrl_t         fs_ctrl;
  logic [IDX_W-1:0] fs_pop_idx;
  logic [CNT_W-1:0] free_top;
  logic [CNT_W-1:0] free_top_after;

  logic                 accept;
  logic                 empty_now;
  logic                 empty_after;
  logic                 fin;
  logic [WORD_BITS-1:0] fin_word;
  status_t              fin_status;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign empty_now = (free_top == CNT_W'(NODES));

  clce_ram #(.DEPTH(NODES), .WIDTH(WORD_BITS)) u_word_ram (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .re(w_re), .raddr(w_raddr), .rdata(w_rdata)
  );

  clce_ram #(.DEPTH(NODES), .WIDTH(IDX_W)) u_prev_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .re(p_re), .raddr(cursor), .rdata(p_rdata)
  );

  clce_ram #(.DEPTH(NODES), .WIDTH(IDX_W)) u_next_ram (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .re(n_re), .raddr(cursor), .rdata(n_rdata)
  );

  clce_free_stack #(.NODES(NODES)) u_free_stack (
    .clk(clk), .rst(rst), .ctrl(fs_ctrl), .push_index(cursor),
    .pop_index(fs_pop_idx), .free_top(free_top)
  );

  // Sequence each command through read, modify and write back
  always_comb begin
    state_next  = state;
    cursor_next = cursor;
    head_next   = head;
    w_we        = 1'b0;
    w_re        = 1'b0;
    w_waddr     = cursor;
    w_wdata     = word_r;
    w_raddr     = cursor;
    p_we        = 1'b0;
    p_re        = 1'b0;
    p_waddr     = cursor;
    p_wdata     = cursor;
    n_we        = 1'b0;
    n_re        = 1'b0;
    n_waddr     = cursor;
    n_wdata     = cursor;
    fs_ctrl     = '0;
    fin         = 1'b0;
    fin_word    = w_rdata;
    fin_status  = ST_OK;

    case (state)
      S_IDLE: begin
        // Fetch the cursor node and the free stack top
        if (accept) begin
          w_re       = 1'b1;
          p_re       = 1'b1;
          n_re       = 1'b1;
          fs_ctrl.rd = 1'b1;
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        if (act_r == ACT_INSERT) begin
          if (free_top == '0) begin
            // Drop the insert: pool full
            fin        = 1'b1;
            fin_status = ST_FULL;
            state_next = S_IDLE;
          end else begin
            w_we    = 1'b1;
            w_waddr = fs_pop_idx;
            p_we    = 1'b1;
            p_waddr = fs_pop_idx;
            n_we    = 1'b1;
            n_waddr = fs_pop_idx;
            if (empty_now) begin
              // First node links to itself
              p_wdata     = fs_pop_idx;
              n_wdata     = fs_pop_idx;
              head_next   = fs_pop_idx;
              cursor_next = fs_pop_idx;
              fs_ctrl.pop = 1'b1;
              fin         = 1'b1;
              fin_word    = word_r;
              state_next  = S_IDLE;
            end else begin
              p_wdata    = cursor;
              n_wdata    = n_rdata;
              state_next = S_LINK;
            end
          end
        end else if (empty_now) begin
          fin        = 1'b1;
          fin_status = ST_EMPTY;
          state_next = S_IDLE;
        end else begin
          case (act_r)
            ACT_EDIT: begin
              w_we       = 1'b1;
              fin        = 1'b1;
              fin_word   = word_r;
              state_next = S_IDLE;
            end
            ACT_REMOVE: begin
              if (n_rdata == cursor) begin
                // Drop the only node
                head_next    = '0;
                cursor_next  = '0;
                fs_ctrl.push = 1'b1;
                fin          = 1'b1;
                state_next   = S_IDLE;
              end else begin
                // Unlink the cursor node and fetch its successor's word
                n_we       = 1'b1;
                n_waddr    = p_rdata;
                n_wdata    = n_rdata;
                p_we       = 1'b1;
                p_waddr    = n_rdata;
                p_wdata    = p_rdata;
                w_re       = 1'b1;
                w_raddr    = n_rdata;
                state_next = S_FETCH;
              end
            end
            ACT_BACK: begin
              w_re       = 1'b1;
              w_raddr    = p_rdata;
              state_next = S_FETCH;
            end
            ACT_FWD: begin
              w_re       = 1'b1;
              w_raddr    = n_rdata;
              state_next = S_FETCH;
            end
            default: begin
              // Read, and the unused codes
              fin        = 1'b1;
              state_next = S_IDLE;
            end
          endcase
        end
      end

      S_LINK: begin
        // Splice the new node between cursor and its old successor
        p_we        = 1'b1;
        p_waddr     = link_nx_r;
        p_wdata     = new_r;
        n_we        = 1'b1;
        n_waddr     = cursor;
        n_wdata     = new_r;
        cursor_next = new_r;
        fs_ctrl.pop = 1'b1;
        fin         = 1'b1;
        fin_word    = word_r;
        state_next  = S_IDLE;
      end

      S_FETCH: begin
        // Move the cursor; on removal free the old node and advance the head if the cursor was at it
        if (act_r == ACT_REMOVE) begin
          fs_ctrl.push = 1'b1;
          cursor_next  = link_nx_r;
          if (cursor == head) begin
            head_next = link_nx_r;
          end
        end else if (act_r == ACT_BACK) begin
          cursor_next = link_pv_r;
        end else begin
          cursor_next = link_nx_r;
        end
        fin        = 1'b1;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign free_top_after = free_top - CNT_W'(fs_ctrl.pop) + CNT_W'(fs_ctrl.push);
  assign empty_after    = (free_top_after == CNT_W'(NODES));

  // Hold state, cursor, head and the response strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cursor <= '0;
      head   <= '0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      cursor <= cursor_next;
      head   <= head_next;
      done   <= fin;
    end
  end

  // Capture the command, the links read for it and the free index
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= cmd.action;
      word_r <= cmd.word[WORD_BITS-1:0];
    end
    if (state == S_EXEC) begin
      link_nx_r <= n_rdata;
      link_pv_r <= p_rdata;
      new_r     <= fs_pop_idx;
    end
  end

  // Build the response word from the state after the command
  always_ff @(posedge clk) begin
    if (fin) begin
      rsp.current_word <= empty_after ? '0 : WORD_W'(fin_word);
      rsp.is_empty     <= empty_after;
      rsp.node_count   <= COUNT_W'(CNT_W'(NODES) - free_top_after);
      rsp.at_head      <= !empty_after && (cursor_next == head_next);
      rsp.status       <= fin_status;
    end
  end

endmodule

`default_nettype wire

// File: sv/clce_ram.sv
// Simple dual port synchronous RAM: one write and one registered read a cycle.
// Generic storage for the node word and link arrays; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module clce_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write the entry; register the read and hold it between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/clce_free_stack.sv
// Stack of free node indices with a registered read of its top entry.
// Depends on clce_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none

module clce_free_stack
  import clce_pkg::*;
#(
  parameter int NODES = CLCE_NODES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  fs_ctrl_t                   ctrl,
  input  logic [$clog2(NODES)-1:0]   push_index,
  output logic [$clog2(NODES)-1:0]   pop_index,
  output logic [$clog2(NODES+1)-1:0] free_top
);

  localparam int IDX_W = $clog2(NODES);
  localparam int CNT_W = $clog2(NODES + 1);

  logic [IDX_W-1:0] mem [NODES];
  logic [CNT_W-1:0] top;
  logic [CNT_W-1:0] low_mark;
  logic [CNT_W-1:0] rd_ptr;
  logic [IDX_W-1:0] mem_q;
  logic [IDX_W-1:0] ptr_q;
  logic             hit_q;

  assign rd_ptr   = top - CNT_W'(1);
  assign free_top = top;

  // Slots below the low mark were never popped and still hold their own index
  assign pop_index = hit_q ? ptr_q : mem_q;

  // Push into the slot at the top; read the top slot on request
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[top[IDX_W-1:0]] <= push_index;
    end
    if (ctrl.rd) begin
      mem_q <= mem[rd_ptr[IDX_W-1:0]];
      ptr_q <= rd_ptr[IDX_W-1:0];
      hit_q <= (rd_ptr < low_mark);
    end
  end

  // Move the top pointer and track the lowest slot ever popped
  always_ff @(posedge clk) begin
    if (rst) begin
      top      <= CNT_W'(NODES);
      low_mark <= CNT_W'(NODES);
    end else if (ctrl.pop) begin
      top <= rd_ptr;
      if (rd_ptr < low_mark) begin
        low_mark <= rd_ptr;
      end
    end else if (ctrl.push) begin
      top <= top + CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// File: sv/clce_checker.sv
// Port-level checker for the circular list cursor editor, bound to the top.
// Depends on clce_pkg and circular_list_cursor_editor_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "circular_list_cursor_editor_assert.svh"

module clce_checker
  import clce_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input rsp_t rsp
);

  logic accept;
  assign accept = start && !busy;

  // An accepted word keeps the block busy for the next cycle
  `CLCE_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy, "busy low after accept")

  // No response can appear right after an accept
  `CLCE_ASSERT_NEXT(a_accept_no_done, clk, rst, accept, !done, "done right after accept")

  // A response comes only once the command has finished
  `CLCE_ASSERT_SAME(a_done_idle, clk, rst, done, !busy, "done while busy")

  // An empty list reports a zero word, no nodes and no head
  `CLCE_ASSERT_SAME(a_empty_rsp, clk, rst, done && rsp.is_empty,
    rsp.current_word == '0 && rsp.node_count == '0 && !rsp.at_head,
    "empty response with stale fields")

  // A full pool cannot be an empty list
  `CLCE_ASSERT_SAME(a_full_nonempty, clk, rst, done && rsp.status == ST_FULL,
    !rsp.is_empty, "pool full reported on empty list")

endmodule

bind circular_list_cursor_editor clce_checker u_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .done(done),
  .rsp(rsp)
);

`default_nettype wire
